// ===== rtl/core/pce_pkg.sv =====
package pce_pkg;

    // default widths of the coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // datapath operation codes
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_LOAD_D    = 4'd2;
    localparam logic [3:0] OP_MUL_LOAD  = 4'd3;
    localparam logic [3:0] OP_MUL_STEP  = 4'd4;
    localparam logic [3:0] OP_SAVE      = 4'd5;
    localparam logic [3:0] OP_SQRT_LOAD = 4'd6;
    localparam logic [3:0] OP_SQRT_STEP = 4'd7;
    localparam logic [3:0] OP_DIV_LOAD  = 4'd8;
    localparam logic [3:0] OP_DIV_STEP  = 4'd9;
    localparam logic [3:0] OP_OUT       = 4'd10;

    // product selects, also the save targets
    localparam logic [2:0] SEL_DDY_DX = 3'd0;
    localparam logic [2:0] SEL_DDX_DY = 3'd1;
    localparam logic [2:0] SEL_DX_DX  = 3'd2;
    localparam logic [2:0] SEL_DY_DY  = 3'd3;
    localparam logic [2:0] SEL_S_ROOT = 3'd4;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] sel;
        logic       first;
        logic       last;
        logic       run_last;
        logic       path_end;
        logic       short_path;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/pce_datapath.sv =====
module pce_datapath #(
    parameter int COORD_WIDTH = pce_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = pce_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pce_pkg::t_dp_cmd              i_cmd,
    output pce_pkg::t_dp_sts              o_sts,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_curvature,
    output logic                          o_run_last,
    output logic                          o_path_end,
    output logic                          o_short_path,
    output logic                          o_clipped
);
    import pce_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int SW  = 2 * W + 2;       // sum of squares
    localparam int RW  = W + 1;           // square root
    localparam int PW  = 3 * W + 4;       // multiplier accumulator
    localparam int NMW = 2 * W + 3;       // numerator magnitude
    localparam int DNW = 3 * W + 3;       // denominator
    localparam int AW  = NMW + 2 * FRAC_BITS;
    localparam int QW  = W + 2;
    localparam int RMW = RW + 2;

    // path window
    logic signed [W-1:0] r_px, r_py, r_ox, r_oy;
    // differences
    logic signed [W:0]   r_dfx, r_dfy, r_dcx, r_dcy, r_dx, r_dy;
    logic signed [W+1:0] r_ddx, r_ddy;
    // multiplier
    logic [PW-1:0]       r_ma, r_acc;
    logic [W+1:0]        r_mb;
    // intermediate results
    logic [SW-1:0]       r_p1, r_sq, r_s, r_sr;
    logic                r_neg;
    logic [NMW-1:0]      r_nmag;
    logic [RW-1:0]       r_root;
    logic [RMW-1:0]      r_qrem;
    logic [DNW-1:0]      r_den, r_drem;
    logic [AW-1:0]       r_dvd;
    logic [QW-1:0]       r_q;
    logic                r_over;
    // output register
    logic                r_valid;

    logic [W+1:0]        cx2, cy2, ox2, oy2, px2, py2;
    logic [W:0]          mag_dx, mag_dy;
    logic [W+1:0]        mag_ddx, mag_ddy;
    logic                s1, s2;
    logic signed [NMW:0] t1, t2, nval;
    logic [RMW+1:0]      q_rem2, q_trial;
    logic [DNW:0]        d_rem2;
    logic                d_ge;
    logic [QW-1:0]       q_next;
    logic [W-1:0]        lim, out_mag;
    logic                clip;
    logic signed [W-1:0] out_val;
    logic                dzero;

    // sign extensions for the window arithmetic
    assign cx2 = {{2{i_point_x[W-1]}}, i_point_x};
    assign cy2 = {{2{i_point_y[W-1]}}, i_point_y};
    assign ox2 = {{2{r_ox[W-1]}}, r_ox};
    assign oy2 = {{2{r_oy[W-1]}}, r_oy};
    assign px2 = {{2{r_px[W-1]}}, r_px};
    assign py2 = {{2{r_py[W-1]}}, r_py};

    // magnitudes and product signs
    assign mag_dx  = r_dx[W]    ? (~r_dx + 1'b1)  : r_dx;
    assign mag_dy  = r_dy[W]    ? (~r_dy + 1'b1)  : r_dy;
    assign mag_ddx = r_ddx[W+1] ? (~r_ddx + 1'b1) : r_ddx;
    assign mag_ddy = r_ddy[W+1] ? (~r_ddy + 1'b1) : r_ddy;
    assign s1 = r_ddy[W+1] ^ r_dx[W];
    assign s2 = r_ddx[W+1] ^ r_dy[W];

    // numerator from the two cross products
    assign t1   = s1 ? -signed'((NMW+1)'(r_p1))  : signed'((NMW+1)'(r_p1));
    assign t2   = s2 ? -signed'((NMW+1)'(r_acc[SW-1:0])) :
                        signed'((NMW+1)'(r_acc[SW-1:0]));
    assign nval = t1 - t2;

    // square root step
    assign q_rem2  = {r_qrem, r_sr[SW-1:SW-2]};
    assign q_trial = (RMW+2)'({r_root, 2'b01});

    // division step
    assign d_rem2 = {r_drem, r_dvd[AW-1]};
    assign d_ge   = d_rem2 >= (DNW+1)'(r_den);
    assign q_next = {r_q[QW-2:0], d_ge};

    // saturation and sign of the result
    assign dzero   = (r_dx == '0) && (r_dy == '0);
    assign lim     = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign clip    = r_over || (r_q > QW'(lim));
    assign out_mag = clip ? lim : r_q[W-1:0];
    assign out_val = r_neg ? -signed'(out_mag) : signed'(out_mag);

    assign o_sts.out_free = !r_valid || !i_stall;

    // window, control of the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px    <= '0;
            r_py    <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_ACCEPT) begin
                if (i_cmd.last) begin
                    r_px <= '0;
                    r_py <= '0;
                    r_ox <= '0;
                    r_oy <= '0;
                end else begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                    r_px <= i_point_x;
                    r_py <= i_point_y;
                end
            end
            if (i_cmd.op == OP_OUT) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_ddx <= cx2 + ox2 - (px2 << 1);
                r_ddy <= cy2 + oy2 - (py2 << 1);
                r_dfx <= px2[W:0] - ox2[W:0];
                r_dfy <= py2[W:0] - oy2[W:0];
                r_dcx <= cx2[W:0] - px2[W:0];
                r_dcy <= cy2[W:0] - py2[W:0];
            end
            OP_LOAD_D: begin
                r_dx <= i_cmd.first ? r_dfx : r_dcx;
                r_dy <= i_cmd.first ? r_dfy : r_dcy;
            end
            OP_MUL_LOAD: begin
                r_acc <= '0;
                case (i_cmd.sel)
                    SEL_DDY_DX: begin
                        r_ma <= PW'(mag_dx);
                        r_mb <= mag_ddy;
                    end
                    SEL_DDX_DY: begin
                        r_ma <= PW'(mag_dy);
                        r_mb <= mag_ddx;
                    end
                    SEL_DX_DX: begin
                        r_ma <= PW'(mag_dx);
                        r_mb <= (W+2)'(mag_dx);
                    end
                    SEL_DY_DY: begin
                        r_ma <= PW'(mag_dy);
                        r_mb <= (W+2)'(mag_dy);
                    end
                    default: begin
                        r_ma <= PW'(r_s);
                        r_mb <= (W+2)'(r_root);
                    end
                endcase
            end
            OP_MUL_STEP: begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            OP_SAVE: begin
                case (i_cmd.sel)
                    SEL_DDY_DX: r_p1 <= r_acc[SW-1:0];
                    SEL_DDX_DY: begin
                        r_neg  <= nval[NMW];
                        r_nmag <= nval[NMW] ? NMW'(-nval) : NMW'(nval);
                    end
                    SEL_DX_DX: r_sq <= r_acc[SW-1:0];
                    SEL_DY_DY: r_s  <= r_sq + r_acc[SW-1:0];
                    default:   r_den <= r_acc[DNW-1:0];
                endcase
            end
            OP_SQRT_LOAD: begin
                r_qrem <= '0;
                r_root <= '0;
                r_sr   <= r_s;
            end
            OP_SQRT_STEP: begin
                if (q_rem2 >= q_trial) begin
                    r_qrem <= RMW'(q_rem2 - q_trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_qrem <= RMW'(q_rem2);
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_sr <= r_sr << 2;
            end
            OP_DIV_LOAD: begin
                r_dvd  <= {r_nmag, {(2*FRAC_BITS){1'b0}}};
                r_drem <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
            end
            OP_DIV_STEP: begin
                r_drem <= d_ge ? DNW'(d_rem2 - (DNW+1)'(r_den)) : DNW'(d_rem2);
                r_dvd  <= r_dvd << 1;
                if (!r_over) begin
                    r_q <= q_next;
                    if (q_next > (QW'(1) << W)) begin
                        r_over <= 1'b1;
                    end
                end
            end
            OP_OUT: begin
                o_run_last   <= i_cmd.run_last;
                o_path_end   <= i_cmd.path_end;
                o_short_path <= i_cmd.short_path;
                if (i_cmd.short_path || dzero) begin
                    o_curvature <= '0;
                    o_clipped   <= 1'b0;
                end else begin
                    o_curvature <= out_val;
                    o_clipped   <= clip;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule

// ===== rtl/core/pce_ctrl.sv =====
module pce_ctrl #(
    parameter int COORD_WIDTH = pce_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = pce_pkg::FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_path_last,
    output logic             o_stall,
    input  pce_pkg::t_dp_sts i_sts,
    output pce_pkg::t_dp_cmd o_cmd
);
    import pce_pkg::*;

    localparam int AW = 4 * COORD_WIDTH + 3 + 2 * FRAC_BITS - COORD_WIDTH - COORD_WIDTH;
    localparam int CW = $clog2(AW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOADD  = 4'd1;
    localparam logic [3:0] S_MLOAD  = 4'd2;
    localparam logic [3:0] S_MSTEP  = 4'd3;
    localparam logic [3:0] S_MSAVE  = 4'd4;
    localparam logic [3:0] S_QLOAD  = 4'd5;
    localparam logic [3:0] S_QSTEP  = 4'd6;
    localparam logic [3:0] S_DLOAD  = 4'd7;
    localparam logic [3:0] S_DSTEP  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_END    = 4'd10;
    localparam logic [3:0] S_SHORT  = 4'd11;

    localparam logic [CW-1:0] MUL_LAST  = CW'(COORD_WIDTH + 1);
    localparam logic [CW-1:0] SQRT_LAST = CW'(COORD_WIDTH);
    localparam logic [CW-1:0] DIV_LAST  = CW'(AW - 1);

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_ps, n_ps;
    logic          r_first, n_first;
    logic          r_last, n_last;
    logic [1:0]    r_nshort, n_nshort;
    logic [2:0]    r_msel, n_msel;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_ps     = r_ps;
        n_first  = r_first;
        n_last   = r_last;
        n_nshort = r_nshort;
        n_msel   = r_msel;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op   = OP_ACCEPT;
                    o_cmd.last = i_path_last;
                    if (r_ps < 2'd2) begin
                        if (i_path_last) begin
                            n_nshort = (r_ps == 2'd1) ? 2'd2 : 2'd1;
                            n_ps     = 2'd0;
                            n_state  = S_SHORT;
                        end else begin
                            n_ps = r_ps + 2'd1;
                        end
                    end else begin
                        n_first = (r_ps == 2'd2);
                        n_last  = i_path_last;
                        n_ps    = i_path_last ? 2'd0 : 2'd3;
                        n_state = S_LOADD;
                    end
                end
            end
            S_LOADD: begin
                o_cmd.op    = OP_LOAD_D;
                o_cmd.first = r_first;
                n_msel      = SEL_DDY_DX;
                n_state     = S_MLOAD;
            end
            S_MLOAD: begin
                o_cmd.op  = OP_MUL_LOAD;
                o_cmd.sel = r_msel;
                n_cnt     = '0;
                n_state   = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.op = OP_MUL_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_MSAVE;
                end
            end
            S_MSAVE: begin
                o_cmd.op  = OP_SAVE;
                o_cmd.sel = r_msel;
                if (r_msel == SEL_S_ROOT) begin
                    n_state = S_DLOAD;
                end else if (r_msel == SEL_DY_DY) begin
                    n_state = S_QLOAD;
                end else begin
                    n_msel  = r_msel + 3'd1;
                    n_state = S_MLOAD;
                end
            end
            S_QLOAD: begin
                o_cmd.op = OP_SQRT_LOAD;
                n_cnt    = '0;
                n_state  = S_QSTEP;
            end
            S_QSTEP: begin
                o_cmd.op = OP_SQRT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_msel  = SEL_S_ROOT;
                    n_state = S_MLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.op = OP_DIV_LOAD;
                n_cnt    = '0;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op       = OP_OUT;
                    o_cmd.run_last = !r_first && !r_last;
                    if (r_first) begin
                        n_first = 1'b0;
                        n_state = S_LOADD;
                    end else if (r_last) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.op       = OP_OUT;
                    o_cmd.run_last = 1'b1;
                    o_cmd.path_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SHORT: begin
                if (i_sts.out_free) begin
                    o_cmd.op         = OP_OUT;
                    o_cmd.short_path = 1'b1;
                    o_cmd.run_last   = (r_nshort == 2'd1);
                    o_cmd.path_end   = (r_nshort == 2'd1);
                    n_nshort         = r_nshort - 2'd1;
                    if (r_nshort == 2'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ps     <= 2'd0;
            r_first  <= 1'b0;
            r_last   <= 1'b0;
            r_nshort <= 2'd0;
            r_msel   <= SEL_DDY_DX;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ps     <= n_ps;
            r_first  <= n_first;
            r_last   <= n_last;
            r_nshort <= n_nshort;
            r_msel   <= n_msel;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/path_curvature_estimator.sv =====
// Signed curvature of a path given one waypoint per transfer (signed fixed point
// x, y and a final-point flag). A result belongs to the waypoint before the one
// that caused it: the third waypoint releases the first two results, and a final
// waypoint adds a repeat of its own result flagged path_end. Each computed result
// is worked out by one shared shift-add multiplier (five products of COORD_WIDTH+2
// steps), a bit-serial square root (COORD_WIDTH+1 steps) and a restoring divider
// (2*COORD_WIDTH+3+2*FRAC_BITS steps); one waypoint may need two such results, and
// the input is stalled while a waypoint is in work. Paths of one or two waypoints
// give zero curvature flagged short_path, one result per cycle while the output
// is not stalled. A result waits in the output register and the next waypoint may
// be taken meanwhile.
module path_curvature_estimator #(
    parameter int COORD_WIDTH = pce_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = pce_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_path_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_curvature,
    output logic                          o_run_last,
    output logic                          o_path_end,
    output logic                          o_short_path,
    output logic                          o_clipped
);
    import pce_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing of one waypoint
    pce_ctrl #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_path_last (i_path_last),
        .o_stall     (o_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // window, arithmetic units and output register
    pce_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_curvature  (o_curvature),
        .o_run_last   (o_run_last),
        .o_path_end   (o_path_end),
        .o_short_path (o_short_path),
        .o_clipped    (o_clipped)
    );

endmodule
